// File: sv/gbsd_pkg.sv
// Shared phase codes for the bit-serial Golomb decoder.
package gbsd_pkg;

  typedef logic [1:0] phase_t;

  // Decoder phase codes; the unused code behaves as the unary phase.
  localparam phase_t PhUnary = 2'd0;
  localparam phase_t PhRem   = 2'd1;
  localparam phase_t PhExtra = 2'd2;

endpackage

// File: sv/golomb_bit_serial_decoder.sv
// Bit-serial Golomb decoder: unary quotient, truncated-binary remainder, zig-zag output.
// Throughput: one code bit per clock, sustained, as long as the result side keeps up.
// The result is registered: its request is valid in the cycle after the bit that ends its code.
// The critical path is the remainder step, the q*m + r add and its saturation compare.
// Reset (rst_ni low, async) returns to the unary phase with empty accumulators,
// no pending result, and the divisor register at 4.
module golomb_bit_serial_decoder
  import gbsd_pkg::*;
#(
  parameter int VALUE_BITS   = 32,
  parameter int DIVISOR_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration: divisor m
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [DIVISOR_BITS-1:0] cfg_data_i,
  // coded bit stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [0] code_bit, rest zero
  // decoded values
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // unsigned_value [VALUE_BITS-1:0], signed_value [2*VALUE_BITS:VALUE_BITS], zero pad above
  output logic [((2*VALUE_BITS+1+7)/8)*8-1:0] m_axis_tdata,
  output logic                    m_axis_tuser    // overflow
);

  localparam int OutBits = ((2 * VALUE_BITS + 1 + 7) / 8) * 8;
  localparam int PadBits = OutBits - (2 * VALUE_BITS + 1);
  localparam int BW      = $clog2(DIVISOR_BITS + 1);  // holds code width 0..DIVISOR_BITS
  localparam int LW      = $clog2(DIVISOR_BITS);      // holds bits left 0..DIVISOR_BITS-1
  localparam int SW      = ((VALUE_BITS > DIVISOR_BITS) ? VALUE_BITS : DIVISOR_BITS) + 1;
  localparam logic [VALUE_BITS-1:0] MaxV = {VALUE_BITS{1'b1}};

  // b = ceil(log2 m), m >= 1
  function automatic logic [BW-1:0] code_width(input logic [DIVISOR_BITS-1:0] m);
    logic [DIVISOR_BITS-1:0] mm;
    logic [BW-1:0]           b;
    mm = m - 1'b1;
    b  = '0;
    for (int i = 0; i < DIVISOR_BITS; i++) begin
      if (mm[i]) b = BW'(i + 1);
    end
    return b;
  endfunction

  // t = 2^b - m
  function automatic logic [DIVISOR_BITS-1:0] code_thresh(input logic [DIVISOR_BITS-1:0] m);
    logic [DIVISOR_BITS:0] t;
    t = ((DIVISOR_BITS + 1)'(1) << code_width(m)) - {1'b0, m};
    return t[DIVISOR_BITS-1:0];
  endfunction

  localparam logic [DIVISOR_BITS-1:0] DivReset = DIVISOR_BITS'(4);

  // Divisor and its derived width / threshold, all settled at write time.
  logic [DIVISOR_BITS-1:0] div_q;
  logic [BW-1:0]           width_q;
  logic [DIVISOR_BITS-1:0] thresh_q;
  logic [DIVISOR_BITS-1:0] cfg_eff;

  assign cfg_ready_o = 1'b1;
  assign cfg_eff     = (cfg_data_i == '0) ? DIVISOR_BITS'(1) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= (DivReset == '0) ? DIVISOR_BITS'(1) : DivReset;
      width_q  <= code_width((DivReset == '0) ? DIVISOR_BITS'(1) : DivReset);
      thresh_q <= code_thresh((DivReset == '0) ? DIVISOR_BITS'(1) : DivReset);
    end else if (cfg_valid_i) begin
      div_q    <= cfg_eff;
      width_q  <= code_width(cfg_eff);
      thresh_q <= code_thresh(cfg_eff);
    end
  end

  // Decoder state
  phase_t                  phase_q, phase_d;
  logic [VALUE_BITS-1:0]   qd_q, qd_d;
  logic [DIVISOR_BITS-1:0] acc_q, acc_d;
  logic [LW-1:0]           left_q, left_d;
  logic                    sat_q, sat_d;
  logic                    emit;

  // Result register
  logic                    out_valid_q;
  logic [VALUE_BITS-1:0]   val_q;
  logic                    ovf_q;

  logic                    in_req;
  logic                    code_bit;
  logic [DIVISOR_BITS-1:0] acc_shift;
  logic [DIVISOR_BITS-1:0] acc_extra;
  logic [SW-1:0]           qd_sum;
  logic [SW-1:0]           val_sum;
  logic                    bits_done;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign code_bit      = s_axis_tdata[0];

  // shift next remainder bit in; acc never exceeds DIVISOR_BITS-1 bits here
  assign acc_shift = {acc_q[DIVISOR_BITS-2:0], code_bit};
  assign acc_extra = (acc_shift >= thresh_q) ? acc_shift - thresh_q : '0;
  assign qd_sum    = SW'(qd_q) + SW'(div_q);

  always_comb begin
    phase_d   = phase_q;
    qd_d      = qd_q;
    acc_d     = acc_q;
    left_d    = left_q;
    sat_d     = sat_q;
    emit      = 1'b0;
    bits_done = 1'b0;
    case (phase_q)
      PhRem: begin
        acc_d     = acc_shift;
        left_d    = (left_q != '0) ? left_q - 1'b1 : left_q;
        bits_done = (left_d == '0);
      end
      PhExtra: begin
        acc_d = acc_extra;
        emit  = 1'b1;
      end
      default: begin
        phase_d = PhUnary;
        if (!code_bit) begin
          // one more unit of quotient
          if (qd_sum > SW'(MaxV)) begin
            qd_d  = MaxV;
            sat_d = 1'b1;
          end else begin
            qd_d = qd_sum[VALUE_BITS-1:0];
          end
        end else begin
          acc_d = '0;
          if (width_q == '0) begin
            emit = 1'b1;          // divisor of one: no remainder bits
          end else begin
            left_d    = LW'(width_q - 1'b1);
            bits_done = (left_d == '0);
            if (!bits_done) phase_d = PhRem;
          end
        end
      end
    endcase
    // remainder bits in: either read the extra bit or finish;
    // a divisor of one written mid-code has no extra bit
    if (bits_done) begin
      if ((width_q != '0) && (acc_d >= thresh_q)) phase_d = PhExtra;
      else                                         emit    = 1'b1;
    end
  end

  assign val_sum = SW'(qd_q) + SW'(acc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhUnary;
      qd_q    <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      sat_q   <= 1'b0;
    end else if (in_req) begin
      if (emit) begin
        phase_q <= PhUnary;
        qd_q    <= '0;
        acc_q   <= '0;
        left_q  <= '0;
        sat_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        qd_q    <= qd_d;
        acc_q   <= acc_d;
        left_q  <= left_d;
        sat_q   <= sat_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_req && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req && emit) begin
      if (val_sum > SW'(MaxV)) begin
        val_q <= MaxV;
        ovf_q <= 1'b1;
      end else begin
        val_q <= val_sum[VALUE_BITS-1:0];
        ovf_q <= sat_q;
      end
    end
  end

  // zig-zag unmap from the result register: even -> -(v/2), odd -> (v+1)/2
  logic [VALUE_BITS:0] half;
  logic [VALUE_BITS:0] zz;

  assign half = {2'b00, val_q[VALUE_BITS-1:1]};
  assign zz   = val_q[0] ? half + 1'b1 : (~half + 1'b1);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadBits{1'b0}}, zz, val_q};
  assign m_axis_tuser  = ovf_q;

`ifndef ASSERT_OFF
  a_left_only_in_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q != '0) |-> (phase_q == PhRem))
    else $error("remainder bit count live outside remainder phase");

  a_sat_holds_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (qd_q == MaxV))
    else $error("saturated flag set without saturated quotient");

  a_zero_bit_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req && (phase_q == PhUnary) && !code_bit) |=> (phase_q == PhUnary))
    else $error("unary zero bit left the unary phase");

  a_extra_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req && (phase_q == PhExtra)) |=> (out_valid_q && (phase_q == PhUnary)))
    else $error("extra bit did not complete the code");
`endif

endmodule
